// ===== src/base64url_decoder_top_defines.svh =====
// Assertion macros for the base64url decoder RTL.
// No dependencies; included by b64u_core, the module that carries assertions.
`ifndef BASE64URL_DECODER_TOP_DEFINES_SVH
`define BASE64URL_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define B64U_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define B64U_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/b64u_pkg.sv =====
// Package for the base64url decoder: symbol class type, alphabet constants
// and the character lookup function. No dependencies.
`default_nettype none

package b64u_pkg;

  localparam int unsigned SymW  = 8;
  localparam int unsigned DigW  = 6;
  localparam int unsigned CntW  = 3;

  localparam logic [DigW-1:0] LowerBase = 6'd26;
  localparam logic [DigW-1:0] DigitBase = 6'd52;
  localparam logic [DigW-1:0] Val62     = 6'd62;
  localparam logic [DigW-1:0] Val63     = 6'd63;

  typedef struct packed {
    logic            is_data;
    logic            is_pad;
    logic [DigW-1:0] value;
  } sym_t;

  function automatic sym_t sym_lookup(input logic [SymW-1:0] c);
    sym_t s;
    logic [SymW-1:0] diff;
    s    = '0;
    diff = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      diff      = c - 8'h41;
      s.is_data = 1'b1;
      s.value   = diff[DigW-1:0];
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      diff      = c - 8'h61;
      s.is_data = 1'b1;
      s.value   = diff[DigW-1:0] + LowerBase;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      diff      = c - 8'h30;
      s.is_data = 1'b1;
      s.value   = diff[DigW-1:0] + DigitBase;
    end else if (c == 8'h2D || c == 8'h2B) begin
      s.is_data = 1'b1;
      s.value   = Val62;
    end else if (c == 8'h5F || c == 8'h2F) begin
      s.is_data = 1'b1;
      s.value   = Val63;
    end else if (c == 8'h3D) begin
      s.is_pad  = 1'b1;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== src/base64url_decoder_top.sv =====
// Top level of the base64url decoder: input register, character classifier
// and bit gatherer. Depends on b64u_pkg, b64u_sym_map and b64u_core.
//
// Streaming base64 decoder taking one character word per cycle unless the
// output stalls, accepting both the URL-safe and the standard alphabet. A
// result word leaves whenever a byte is complete and on the last character of
// each message; the end word carries the status, set when an invalid character
// was seen, in which case bytes already delivered should be discarded.
// Sustained rate is one word per clock unless m_tready stalls the output, set
// by the combinational lookup and gather step between the input and result
// registers. Reset clears all control state at once, no clearing pass needed.
`default_nettype none

module base64url_decoder_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // symbol
  input  wire logic       s_tlast,   // last_symbol
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // out_byte
  output logic            m_tlast,   // end_of_message
  output logic [1:0]      m_tuser    // bit 0 byte_present, bit 1 status
);
  import b64u_pkg::*;

  logic            in_valid;
  logic [SymW-1:0] in_symbol;
  logic            in_last;
  logic            take;
  sym_t            sym;

  assign s_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (take) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_symbol <= s_tdata;
      in_last   <= s_tlast;
    end
  end

  b64u_sym_map u_sym_map (
    .symbol (in_symbol),
    .sym    (sym)
  );

  b64u_core u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_last  (in_last),
    .sym      (sym),
    .take     (take),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

// ===== src/b64u_sym_map.sv =====
// Character classifier: maps one eight-bit character to its six-bit value,
// a padding mark or an invalid mark. Depends on b64u_pkg.
`default_nettype none

module b64u_sym_map (
  input  wire logic [b64u_pkg::SymW-1:0] symbol,
  output b64u_pkg::sym_t                 sym
);
  import b64u_pkg::*;

  always_comb begin
    sym = sym_lookup(symbol);
  end

endmodule

`default_nettype wire

// ===== src/b64u_core.sv =====
// Bit gatherer and result register of the base64url decoder: holds the
// leftover bits, padding and error flags. Depends on b64u_pkg and the defines.
`default_nettype none
`include "base64url_decoder_top_defines.svh"

module b64u_core (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire logic                      in_last,
  input  wire b64u_pkg::sym_t            sym,
  output logic                           take,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [7:0]                     m_tdata,  // out_byte
  output logic                           m_tlast,  // end_of_message
  output logic [1:0]                     m_tuser   // byte_present, status
);
  import b64u_pkg::*;

  logic [DigW-1:0] leftover_bits;
  logic [DigW-1:0] leftover_bits_next;
  logic [CntW-1:0] bit_count;
  logic [CntW-1:0] bit_count_next;
  logic            padding_seen;
  logic            error_seen;

  logic            active;
  logic            is_invalid;
  logic [3:0]      bits_sum;
  logic [3:0]      bits_cap;
  logic [3:0]      shift_wide;
  logic [CntW-1:0] shift;
  logic [11:0]     acc;
  logic [11:0]     acc_shifted;
  logic [11:0]     rem_mask;
  logic [11:0]     acc_kept;
  logic            emit;
  logic            has_result;
  logic            status;

  always_comb begin
    active      = !padding_seen && !error_seen;
    is_invalid  = !sym.is_data && !sym.is_pad;
    bits_sum    = {1'b0, bit_count} + 4'd6;
    bits_cap    = (bits_sum > 4'd12) ? 4'd12 : bits_sum;
    shift_wide  = bits_cap - 4'd8;
    shift       = shift_wide[CntW-1:0];
    acc         = {leftover_bits, sym.value};
    acc_shifted = acc >> shift;
    rem_mask    = ~(12'hFFF << shift);
    acc_kept    = acc & rem_mask;
    emit        = active && sym.is_data && (bits_cap >= 4'd8);
    has_result  = emit || in_last;
    status      = in_last && (error_seen || (active && is_invalid));
    take        = in_valid && (!has_result || !m_tvalid || m_tready);
    if (emit) begin
      leftover_bits_next = acc_kept[DigW-1:0];
      bit_count_next     = shift;
    end else begin
      leftover_bits_next = acc[DigW-1:0];
      bit_count_next     = bits_cap[CntW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leftover_bits <= '0;
      bit_count     <= '0;
      padding_seen  <= 1'b0;
      error_seen    <= 1'b0;
    end else if (take) begin
      if (in_last) begin
        leftover_bits <= '0;
        bit_count     <= '0;
        padding_seen  <= 1'b0;
        error_seen    <= 1'b0;
      end else if (active) begin
        if (is_invalid) begin
          error_seen <= 1'b1;
        end else if (sym.is_pad) begin
          padding_seen <= 1'b1;
        end else begin
          leftover_bits <= leftover_bits_next;
          bit_count     <= bit_count_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take && has_result) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && has_result) begin
      m_tdata <= emit ? acc_shifted[7:0] : 8'h00;
      m_tlast <= in_last;
      m_tuser <= {status, emit};
    end
  end

  `B64U_ASSERT_IMPL(a_count_even, clk, rst, 1'b1,
    bit_count == 3'd0 || bit_count == 3'd2 || bit_count == 3'd4 || bit_count == 3'd6,
    "leftover bit count left the even values")
  `B64U_ASSERT_IMPL(a_leftover_clean, clk, rst, bit_count == 3'd0,
    leftover_bits == '0, "stale leftover bits with an empty count")
  `B64U_ASSERT_NEXT(a_clear_after_end, clk, rst, take && in_last,
    bit_count == '0 && !padding_seen && !error_seen, "state not cleared after message end")
  `B64U_ASSERT_IMPL(a_result_meaningful, clk, rst, m_tvalid,
    m_tuser[0] || m_tlast, "result word with neither byte nor end")
  `B64U_ASSERT_IMPL(a_status_on_end, clk, rst, m_tvalid && m_tuser[1],
    m_tlast, "invalid status on a word that does not end the message")

endmodule

`default_nettype wire
